/* rtl/asidalloc_pkg.sv */
package asidalloc_pkg;

  localparam int CTX_W  = 64;
  localparam int GEN_W  = 48;
  localparam int ASID_W = 16;
  localparam int CPU_W  = 3;
  localparam int REQ_W  = 2;

  localparam int DEF_NUM_ASIDS = 65536;
  localparam int DEF_NUM_CPUS  = 8;
  localparam int DEF_WORD_BITS = 64;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

endpackage

/* rtl/asidalloc_if.sv */
interface asidalloc_req_if import asidalloc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CPU_W-1:0] cpu_index;
  logic [CTX_W-1:0] context_in;
  logic             set_active;
  logic             target_present;

  modport source (output valid, req_type, cpu_index, context_in, set_active, target_present,
                  input ready);
  modport sink   (input valid, req_type, cpu_index, context_in, set_active, target_present,
                  output ready);
endinterface

interface asidalloc_rsp_if import asidalloc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CTX_W-1:0]  context_out;
  logic [CTX_W-1:0]  old_context;
  logic [ASID_W-1:0] asid_out;
  logic              flush_valid;
  logic              rolled_over;

  modport source (output valid, context_out, old_context, asid_out, flush_valid, rolled_over,
                  input ready);
  modport sink   (input valid, context_out, old_context, asid_out, flush_valid, rolled_over,
                  output ready);
endinterface

/* rtl/asid_allocator_with_rollover_core.sv */
// Path from accept to result: a no-op, an ignored free, an allocate of a current context and
// a switch without reallocation go straight to S_FIN; a free that clears a bit first passes S_FRD, S_FWR.
// A fresh allocate reads and checks used-map words (S_SRD, S_SCHK) one by one, starting at the lowest word
// that may hold a free asid; rollover clears every map word and re-marks each cpu's asid (S_MRD, S_MWR).
// One item at a time; the next item is taken once the result is registered.
// Reset: clears the used map one word a cycle, no item taken.
module asid_allocator_with_rollover_core import asidalloc_pkg::*; #(
  parameter int NUM_ASIDS = DEF_NUM_ASIDS,
  parameter int NUM_CPUS  = DEF_NUM_CPUS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asidalloc_req_if.sink   req_i,
  asidalloc_rsp_if.source rsp_o
);

  // NUM_ASIDS and WORD_BITS are powers of two
  localparam int MAP_WORDS = NUM_ASIDS / WORD_BITS;
  localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIW       = $clog2(WORD_BITS);
  localparam int CPU_IW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_FWR  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SCHK = 4'd5;
  localparam logic [3:0] S_MRD  = 4'd6;
  localparam logic [3:0] S_MWR  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]          state_q;
  logic [WIW:0]        clr_q, scan_q, hint_q;
  logic [GEN_W-1:0]    gen_q;
  logic [CTX_W-1:0]    act_q [NUM_CPUS];
  logic [CPU_IW-1:0]   mark_q;
  logic [ASID_W-1:0]   ma_q;

  logic [CTX_W-1:0]    ctx_q;
  logic [CPU_IW-1:0]   cidx_q;
  logic                cpu_ok_q, set_q, rolled_q;
  logic [CTX_W-1:0]    res_ctx_q, res_old_q;
  logic                res_flush_q;

  logic                out_valid_q;
  logic [CTX_W-1:0]    out_ctx_q, out_old_q;
  logic                out_flush_q, out_rolled_q;

  logic [WORD_BITS-1:0] used_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_en, wr_en;
  logic [WIW-1:0]       rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // request decode
  logic [CPU_IW+CPU_W-1:0] cwide;
  logic [CPU_IW-1:0]       cidx;
  logic                    cpu_ok;
  logic [CTX_W-1:0]        act_rd, next_ctx;
  logic                    gen_cur, accept;
  logic [ASID_W-1:0]       ctx_asid;

  assign cwide    = {{CPU_IW{1'b0}}, req_i.cpu_index};
  assign cidx     = cwide[CPU_IW-1:0];
  assign cpu_ok   = cwide < (CPU_IW+CPU_W)'(NUM_CPUS);
  assign act_rd   = cpu_ok ? act_q[cidx] : '0;
  assign gen_cur  = req_i.context_in[CTX_W-1:ASID_W] == gen_q;
  assign next_ctx = req_i.target_present ? req_i.context_in : {gen_q, {ASID_W{1'b0}}};
  assign accept   = req_i.valid && req_i.ready;
  assign ctx_asid = req_i.context_in[ASID_W-1:0];
  assign req_i.ready = (state_q == S_IDLE);

  function automatic logic asid_ok(logic [ASID_W-1:0] a);
    return {1'b0, a} < (ASID_W+1)'(NUM_ASIDS);
  endfunction

  // what an accepted item starts with
  logic [CTX_W-1:0] dec_ctx, dec_old, dec_act;
  logic             dec_flush, dec_set, dec_act_we;
  logic [3:0]       dec_state;
  always_comb begin
    dec_ctx    = '0;
    dec_old    = '0;
    dec_flush  = 1'b0;
    dec_set    = req_i.set_active;
    dec_act_we = 1'b0;
    dec_act    = next_ctx;
    dec_state  = S_FIN;
    case (req_i.req_type)
      REQ_ALLOC: begin
        dec_flush = 1'b1;
        if (gen_cur) begin
          dec_ctx    = req_i.context_in;
          dec_act_we = req_i.set_active && cpu_ok;
          dec_act    = req_i.context_in;
        end else begin
          dec_state = S_SRD;
        end
      end
      REQ_FREE: begin
        if (gen_cur && ctx_asid != '0 && asid_ok(ctx_asid)) dec_state = S_FRD;
      end
      REQ_SWITCH: begin
        dec_old    = act_rd;
        dec_ctx    = next_ctx;
        dec_set    = 1'b1;
        dec_act_we = cpu_ok;
        if (req_i.target_present &&
            act_rd[CTX_W-1:ASID_W] != req_i.context_in[CTX_W-1:ASID_W]) begin
          dec_flush = 1'b1;
          if (!gen_cur) dec_state = S_SRD;
        end
      end
      default: ;
    endcase
  end

  // lowest free bit of the word under scan
  logic [WORD_BITS-1:0] avail;
  logic [BIW-1:0]       low_bit;
  always_comb begin
    avail   = ~rdata_q;
    low_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) low_bit = BIW'(b);
    end
  end

  logic [ASID_W-1:0] found_asid, mark_asid;
  logic [WIW-1:0]    ctx_word, ma_word;
  logic [BIW-1:0]    ctx_bit, ma_bit;
  assign found_asid = ASID_W'({scan_q[WIW-1:0], low_bit});
  assign mark_asid  = act_q[mark_q][ASID_W-1:0];
  assign ctx_word   = ctx_q[BIW +: WIW];
  assign ctx_bit    = ctx_q[BIW-1:0];
  assign ma_word    = ma_q[BIW +: WIW];
  assign ma_bit     = ma_q[BIW-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_q)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q[WIW-1:0];
        wr_data = WORD_BITS'(clr_q == '0);
      end
      S_FRD: begin
        rd_en   = 1'b1;
        rd_addr = ctx_word;
      end
      S_FWR: begin
        wr_en   = 1'b1;
        wr_addr = ctx_word;
        wr_data = rdata_q & ~(WORD_BITS'(1) << ctx_bit);
      end
      S_SRD: begin
        rd_en   = scan_q < (WIW+1)'(MAP_WORDS);
        rd_addr = scan_q[WIW-1:0];
      end
      S_SCHK: begin
        wr_en   = avail != '0;
        wr_addr = scan_q[WIW-1:0];
        wr_data = rdata_q | (WORD_BITS'(1) << low_bit);
      end
      S_MRD: begin
        rd_en   = (mark_asid != '0) && asid_ok(mark_asid);
        rd_addr = mark_asid[BIW +: WIW];
      end
      S_MWR: begin
        wr_en   = 1'b1;
        wr_addr = ma_word;
        wr_data = rdata_q | (WORD_BITS'(1) << ma_bit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) used_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      scan_q      <= '0;
      hint_q      <= '0;
      gen_q       <= GEN_W'(1);
      mark_q      <= '0;
      rolled_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CPUS; c++) act_q[c] <= '0;
    end else begin
      if (rsp_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          if (clr_q == (WIW+1)'(MAP_WORDS - 1)) begin
            clr_q  <= '0;
            hint_q <= '0;
            mark_q <= '0;
            state_q <= rolled_q ? S_MRD : S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ctx_q       <= req_i.context_in;
            cidx_q      <= cidx;
            cpu_ok_q    <= cpu_ok;
            set_q       <= dec_set;
            rolled_q    <= 1'b0;
            res_ctx_q   <= dec_ctx;
            res_old_q   <= dec_old;
            res_flush_q <= dec_flush;
            scan_q      <= hint_q;
            state_q     <= dec_state;
            if (dec_act_we) act_q[cidx] <= dec_act;
          end
        end
        S_FRD: state_q <= S_FWR;
        S_FWR: begin
          if ({1'b0, ctx_word} < hint_q) hint_q <= {1'b0, ctx_word};
          state_q <= S_FIN;
        end
        S_SRD: begin
          if (scan_q < (WIW+1)'(MAP_WORDS)) begin
            state_q <= S_SCHK;
          end else if (!rolled_q) begin
            // no free asid: bump generation, then clear and re-reserve
            gen_q    <= gen_q + 1'b1;
            rolled_q <= 1'b1;
            clr_q    <= '0;
            state_q  <= S_CLR;
          end else begin
            res_ctx_q <= {gen_q, {ASID_W{1'b0}}};
            if (set_q && cpu_ok_q) act_q[cidx_q] <= {gen_q, {ASID_W{1'b0}}};
            state_q <= S_FIN;
          end
        end
        S_SCHK: begin
          if (avail != '0) begin
            hint_q    <= scan_q;
            res_ctx_q <= {gen_q, found_asid};
            if (set_q && cpu_ok_q) act_q[cidx_q] <= {gen_q, found_asid};
            state_q <= S_FIN;
          end else begin
            scan_q  <= scan_q + 1'b1;
            hint_q  <= scan_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_MRD: begin
          ma_q <= mark_asid;
          act_q[mark_q] <= {gen_q, mark_asid};
          if (mark_asid != '0 && asid_ok(mark_asid)) begin
            state_q <= S_MWR;
          end else if (mark_q == CPU_IW'(NUM_CPUS - 1)) begin
            scan_q  <= '0;
            state_q <= S_SRD;
          end else begin
            mark_q <= mark_q + 1'b1;
          end
        end
        S_MWR: begin
          if (mark_q == CPU_IW'(NUM_CPUS - 1)) begin
            scan_q  <= '0;
            state_q <= S_SRD;
          end else begin
            mark_q  <= mark_q + 1'b1;
            state_q <= S_MRD;
          end
        end
        S_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_ctx_q    <= res_ctx_q;
            out_old_q    <= res_old_q;
            out_flush_q  <= res_flush_q;
            out_rolled_q <= rolled_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.context_out = out_ctx_q;
  assign rsp_o.old_context = out_old_q;
  assign rsp_o.asid_out    = out_ctx_q[ASID_W-1:0];
  assign rsp_o.flush_valid = out_flush_q;
  assign rsp_o.rolled_over = out_rolled_q;

endmodule

/* rtl/asidalloc_chk.sv */
module asidalloc_chk import asidalloc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CTX_W-1:0]  context_out,
  input logic [ASID_W-1:0] asid_out,
  input logic              flush_valid,
  input logic              rolled_over
);

  // items are worked one at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(context_out))
    else $error("result dropped or changed while stalled");

  a_asid_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> asid_out == context_out[ASID_W-1:0])
    else $error("asid_out does not match context_out");

  a_roll_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rolled_over |-> flush_valid)
    else $error("rollover reported without an allocation");

endmodule

bind asid_allocator_with_rollover_core asidalloc_chk u_asidalloc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (req_i.valid),
  .in_ready    (req_i.ready),
  .out_valid   (rsp_o.valid),
  .out_ready   (rsp_o.ready),
  .context_out (rsp_o.context_out),
  .asid_out    (rsp_o.asid_out),
  .flush_valid (rsp_o.flush_valid),
  .rolled_over (rsp_o.rolled_over)
);
